FILE: sv/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants of the keyframe curve evaluator
// Item formats, register indexes, mode codes and the requests and responses of
// the shared multiply and divide units.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned WORD_W          = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned CALC_W          = 48;
  localparam int unsigned MUL_DIGIT_W     = 16;
  localparam int unsigned PTR_W           = 12;
  localparam int unsigned LEN_W           = 9;
  localparam int unsigned MODE_W          = 3;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned SCALE_SH        = 4;
  localparam int unsigned LIN_SH          = 8;
  localparam int unsigned STEP_SH         = 12;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVAL_MODE     = 2'd0,
    CFG_TABLE_LENGTH  = 2'd1,
    CFG_CHANGE_OFFSET = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR  = 3'd0,
    MODE_STEP    = 3'd1,
    MODE_SMOOTH  = 3'd2,
    MODE_LOOP    = 3'd3,
    MODE_CHANGED = 3'd4
  } eval_mode_e;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         word_index;
    logic signed [WORD_W-1:0] word_value;
    logic signed [TIME_W-1:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] curve_value;
    logic                     zero_weight_fault;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [CALC_W-1:0] a;
    logic [CALC_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [CALC_W-1:0] num;
    logic [CALC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CALC_W-1:0] value;
  } unit_rsp_t;

endpackage

FILE: sv/kce_mul.sv
// ----------------------------------------------------------------------------
// kce_mul: shared 48-bit multiplier
// Forms the low 48 bits of a product, one 16-bit digit of the second operand
// per cycle.
// ----------------------------------------------------------------------------
module kce_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kce_pkg::mul_req_t   req_i,
  output kce_pkg::unit_rsp_t  rsp_o
);
  import kce_pkg::*;

  localparam int unsigned Steps = CALC_W / MUL_DIGIT_W;
  localparam int unsigned CntW  = (Steps > 1) ? $clog2(Steps) : 1;

  logic                          busy_q;
  logic                          done_q;
  logic [CntW-1:0]               cnt_q;
  logic [CALC_W-1:0]             a_q;
  logic [CALC_W-1:0]             b_q;
  logic [CALC_W-1:0]             acc_q;
  logic [CALC_W+MUL_DIGIT_W-1:0] part;

  assign part = a_q * b_q[MUL_DIGIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == CntW'(Steps - 1));
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_q + part[CALC_W-1:0];
        a_q   <= a_q << MUL_DIGIT_W;
        b_q   <= b_q >> MUL_DIGIT_W;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

FILE: sv/kce_div.sv
// ----------------------------------------------------------------------------
// kce_div: shared 48-bit signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the quotient
// truncates toward zero and wraps to 48 bits.
// ----------------------------------------------------------------------------
module kce_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kce_pkg::div_req_t   req_i,
  output kce_pkg::unit_rsp_t  rsp_o
);
  import kce_pkg::*;

  localparam int unsigned CntW = $clog2(CALC_W);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [CALC_W:0]   rem_q;
  logic [CALC_W-1:0] quo_q;
  logic [CALC_W-1:0] den_q;
  logic [CALC_W:0]   rem_sh;
  logic [CALC_W:0]   diff;

  assign rem_sh = {rem_q[CALC_W-1:0], quo_q[CALC_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == CntW'(CALC_W - 1));
      if (req_i.start) begin
        quo_q  <= req_i.num[CALC_W-1] ? -req_i.num : req_i.num;
        den_q  <= req_i.den[CALC_W-1] ? -req_i.den : req_i.den;
        neg_q  <= req_i.num[CALC_W-1] ^ req_i.den[CALC_W-1];
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!diff[CALC_W]) begin
          rem_q <= diff;
          quo_q <= {quo_q[CALC_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[CALC_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(CALC_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = neg_q ? -quo_q : quo_q;

endmodule

FILE: sv/keyframe_curve_evaluator.sv
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator: keyframe animation curve evaluation
// Holds a table of keyframe words and evaluates the curve at a given time in
// one of five modes, using one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                  payload
//   cfg       in          cfg_we_i                   cfg_idx_i, cfg_data_i
//   in        in          in_valid_i / in_stall_o    in_item_i (in_item_t)
//   out       out         out_valid_o / out_stall_i  out_item_o (out_item_t)
//
// A load item writes its word and goes straight to output. The linear and step
// walks read a value and a duration word per key (changed detection walks
// twice), the smooth walk a duration word per key. The table memory port (one
// read per cycle) and the shared multiplier and divider set the pace.
// Reset clears control state and sets mode linear, table length 3 and offset
// zero; table words are undefined until loaded. An output stall holds only the
// finished result, in S_DONE, and keeps the input stalled meanwhile.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator #(
  parameter int unsigned TABLE_DEPTH = kce_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  kce_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output kce_pkg::out_item_t                 out_item_o
);
  import kce_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic signed [PTR_W-1:0] P1 = 1;
  localparam logic signed [PTR_W-1:0] P2 = 2;
  localparam logic signed [PTR_W-1:0] P3 = 3;
  localparam logic signed [PTR_W-1:0] P4 = 4;

  typedef enum logic [5:0] {
    S_IDLE, W_VAL, W_VAL2, W_DUR, W_DUR2, W_NXT, W_NXT2, W_MUL, W_DIV, W_END,
    S_CHK, S_RET, S_DUR2, S_NX, S_NX2, S_V2, S_W2, S_WE, S_M1, S_M1W, S_M2W,
    S_FWD, S_FD, S_FF, S_C1, S_C2, S_C3, S_ADD, S_ADDW, S_BWD, S_FIN, S_FDIV,
    S_DONE
  } state_e;

  function automatic logic signed [CALC_W-1:0] sext_w(input logic [WORD_W-1:0] w);
    return {{(CALC_W-WORD_W){w[WORD_W-1]}}, w};
  endfunction

  function automatic logic signed [CALC_W-1:0] scale16(input logic [WORD_W-1:0] w);
    return sext_w(w) <<< SCALE_SH;
  endfunction

  // Signed shift that truncates toward zero.
  function automatic logic signed [CALC_W-1:0] tdiv(input logic [TIME_W+1:0] x,
                                                    input int unsigned sh);
    logic [TIME_W+1:0] mag;
    logic [TIME_W+1:0] r;
    mag = x[TIME_W+1] ? -x : x;
    mag = mag >> sh;
    r   = x[TIME_W+1] ? -mag : mag;
    return {{(CALC_W-TIME_W-2){r[TIME_W+1]}}, r};
  endfunction

  // Table memory.
  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              oob_q;
  logic signed [PTR_W-1:0] rd_addr;
  logic [AW-1:0]     rd_idx;
  logic [WORD_W-1:0] rd_word;
  logic              mem_we;

  // Configuration.
  logic [MODE_W-1:0]        mode_q;
  logic [LEN_W-1:0]         len_q;
  logic signed [TIME_W-1:0] off_q;

  // Sequencer and datapath.
  state_e                   state_q;
  logic                     step_q;
  logic                     chg_q;
  logic                     second_q;
  logic                     loop_q;
  logic                     wraps_q;
  logic                     side_q;
  logic                     near_q;
  logic                     fault_q;
  logic signed [PTR_W-1:0]  p_q;
  logic signed [TIME_W-1:0] time_q;
  logic signed [CALC_W-1:0] t_q;
  logic signed [CALC_W-1:0] res_q;
  logic signed [CALC_W-1:0] first_q;
  logic signed [CALC_W-1:0] total_q;
  logic signed [CALC_W-1:0] weight_q;
  logic [WORD_W-1:0]        valr_q;
  logic [WORD_W-1:0]        durr_q;
  logic [WORD_W-1:0]        nxr_q;
  logic [WORD_W-1:0]        w2_q;
  logic [WORD_W-1:0]        fd_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;

  logic signed [PTR_W-1:0]  len_s;
  logic signed [PTR_W-1:0]  end_s;
  logic signed [CALC_W-1:0] dur16;
  logic signed [CALC_W-1:0] v16;
  logic signed [CALC_W-1:0] nx16;
  logic signed [CALC_W-1:0] dmt;
  logic signed [CALC_W-1:0] t_lin;
  logic signed [CALC_W-1:0] t_smo;
  logic signed [TIME_W+1:0] shifted;
  logic                     fwd_near;
  logic                     bwd_near;
  logic                     accept;
  mul_req_t                 mul_req;
  div_req_t                 div_req;
  unit_rsp_t                mul_rsp;
  unit_rsp_t                div_rsp;

  assign accept  = in_valid_i && !in_stall_o;
  assign len_s   = $signed({{(PTR_W-LEN_W){1'b0}}, len_q});
  assign end_s   = len_s - P1;
  assign dur16   = scale16(durr_q);
  assign v16     = scale16(valr_q);
  assign nx16    = scale16(nxr_q);
  assign dmt     = dur16 - t_q;
  assign t_lin   = t_q - (step_q ? sext_w(rd_word) : scale16(rd_word));
  assign t_smo   = t_q - scale16(rd_word);
  assign shifted = {{2{time_q[TIME_W-1]}}, time_q} + {{2{off_q[TIME_W-1]}}, off_q};
  assign fwd_near = (p_q + P3) < end_s;
  assign bwd_near = p_q > P2;

  // Read address for the word that the next state consumes.
  always_comb begin
    case (state_q)
      S_CHK:   rd_addr = (end_s <= p_q) ? p_q : p_q + P1;
      S_NX:    rd_addr = p_q + P2;
      S_V2:    rd_addr = P2;
      S_W2:    rd_addr = end_s;
      S_FWD:   rd_addr = fwd_near ? p_q + P3 : P3;
      S_BWD:   rd_addr = bwd_near ? p_q - P1 : end_s - P1;
      S_FD: begin
        if (side_q) begin
          rd_addr = near_q ? p_q - P2 : end_s - P2;
        end else begin
          rd_addr = near_q ? p_q + P4 : P4;
        end
      end
      default: rd_addr = p_q;
    endcase
  end

  assign rd_idx  = AW'(rd_addr[PTR_W-2:0]);
  assign rd_word = oob_q ? '0 : rdata_q;
  assign mem_we  = accept && (in_item_i.kind == KIND_LOAD) &&
                   (int'(in_item_i.word_index) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(in_item_i.word_index)] <= in_item_i.word_value;
    end
    rdata_q <= mem[rd_idx];
    oob_q   <= rd_addr[PTR_W-1] || (int'(rd_addr) >= TABLE_DEPTH);
  end

  // Requests to the shared units.
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_q)
      W_NXT2: begin
        mul_req.start = (durr_q != '0);
        mul_req.a     = t_q;
        mul_req.b     = sext_w(rd_word) - sext_w(valr_q);
      end
      W_MUL: begin
        div_req.start = mul_rsp.done;
        div_req.num   = mul_rsp.value;
        div_req.den   = sext_w(durr_q);
      end
      S_M1: begin
        mul_req.start = 1'b1;
        mul_req.a     = v16;
        mul_req.b     = dur16;
      end
      S_M1W: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = t_q;
        mul_req.b     = nx16 - v16;
      end
      S_FF: begin
        mul_req.start = (fd_q != '0);
        mul_req.a     = sext_w(side_q ? valr_q : nxr_q) - sext_w(rd_word);
        mul_req.b     = dmt;
      end
      S_C1: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = t_q;
        mul_req.b     = mul_rsp.value;
      end
      S_C2: begin
        div_req.start = mul_rsp.done;
        div_req.num   = mul_rsp.value;
        div_req.den   = sext_w(fd_q);
      end
      S_ADD: begin
        mul_req.start = 1'b1;
        mul_req.a     = side_q ? v16 : nx16;
        mul_req.b     = side_q ? dmt : t_q;
      end
      S_FIN: begin
        div_req.start = (weight_q != '0);
        div_req.num   = total_q;
        div_req.den   = weight_q;
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  kce_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  kce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LINEAR;
      len_q       <= LEN_W'(3);
      off_q       <= '0;
      state_q     <= S_IDLE;
      step_q      <= 1'b0;
      chg_q       <= 1'b0;
      second_q    <= 1'b0;
      loop_q      <= 1'b0;
      wraps_q     <= 1'b0;
      side_q      <= 1'b0;
      near_q      <= 1'b0;
      fault_q     <= 1'b0;
      p_q         <= '0;
      time_q      <= '0;
      t_q         <= '0;
      res_q       <= '0;
      first_q     <= '0;
      total_q     <= '0;
      weight_q    <= '0;
      valr_q      <= '0;
      durr_q      <= '0;
      nxr_q       <= '0;
      w2_q        <= '0;
      fd_q        <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EVAL_MODE:     mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_TABLE_LENGTH:  len_q  <= cfg_data_i[LEN_W-1:0];
          CFG_CHANGE_OFFSET: off_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // In S_DONE the output register is handled by the state itself.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fault_q  <= 1'b0;
            res_q    <= '0;
            time_q   <= in_item_i.sample_time;
            p_q      <= P2;
            chg_q    <= 1'b0;
            second_q <= 1'b0;
            step_q   <= 1'b0;
            loop_q   <= 1'b0;
            if (in_item_i.kind == KIND_LOAD) begin
              state_q <= S_DONE;
            end else begin
              case (mode_q)
                MODE_LINEAR: begin
                  t_q     <= tdiv({{2{in_item_i.sample_time[TIME_W-1]}},
                                   in_item_i.sample_time}, LIN_SH);
                  state_q <= W_VAL;
                end
                MODE_STEP, MODE_CHANGED: begin
                  t_q     <= tdiv({{2{in_item_i.sample_time[TIME_W-1]}},
                                   in_item_i.sample_time}, STEP_SH);
                  step_q  <= 1'b1;
                  chg_q   <= (mode_q == MODE_CHANGED);
                  state_q <= W_VAL;
                end
                MODE_SMOOTH, MODE_LOOP: begin
                  t_q     <= tdiv({{2{in_item_i.sample_time[TIME_W-1]}},
                                   in_item_i.sample_time}, LIN_SH);
                  loop_q  <= (mode_q == MODE_LOOP);
                  state_q <= S_CHK;
                end
                default: state_q <= S_DONE;
              endcase
            end
          end
        end

        // Linear and step walk.
        W_VAL: state_q <= W_VAL2;
        W_VAL2: begin
          valr_q <= rd_word;
          p_q    <= p_q + P1;
          if (len_s <= p_q + P1) begin
            res_q   <= scale16(rd_word);
            state_q <= W_END;
          end else begin
            state_q <= W_DUR;
          end
        end
        W_DUR: state_q <= W_DUR2;
        W_DUR2: begin
          durr_q <= rd_word;
          p_q    <= p_q + P1;
          t_q    <= t_lin;
          if (!t_lin[CALC_W-1]) begin
            state_q <= W_VAL;
          end else if (step_q) begin
            res_q   <= v16;
            state_q <= W_END;
          end else begin
            state_q <= W_NXT;
          end
        end
        W_NXT: state_q <= W_NXT2;
        W_NXT2: begin
          nxr_q <= rd_word;
          if (durr_q == '0) begin
            res_q   <= scale16(rd_word);
            state_q <= W_END;
          end else begin
            state_q <= W_MUL;
          end
        end
        W_MUL: begin
          if (mul_rsp.done) begin
            state_q <= W_DIV;
          end
        end
        W_DIV: begin
          if (div_rsp.done) begin
            res_q   <= $signed(div_rsp.value) + nx16;
            state_q <= W_END;
          end
        end
        W_END: begin
          if (!chg_q) begin
            state_q <= S_DONE;
          end else if (!second_q) begin
            // Second step lookup at the shifted time, unless it is negative.
            first_q <= res_q;
            if (shifted[TIME_W+1]) begin
              state_q <= S_DONE;
            end else begin
              t_q      <= tdiv(shifted, STEP_SH);
              p_q      <= P2;
              second_q <= 1'b1;
              state_q  <= W_VAL;
            end
          end else begin
            res_q   <= (first_q == res_q) ? '1 : first_q;
            state_q <= S_DONE;
          end
        end

        // Smooth walk and blend.
        S_CHK: state_q <= (end_s <= p_q) ? S_RET : S_DUR2;
        S_RET: begin
          res_q   <= scale16(rd_word);
          state_q <= S_DONE;
        end
        S_DUR2: begin
          durr_q <= rd_word;
          if (!t_smo[CALC_W-1]) begin
            t_q     <= t_smo;
            p_q     <= p_q + P2;
            state_q <= S_CHK;
          end else begin
            state_q <= S_NX;
          end
        end
        S_NX: state_q <= S_NX2;
        S_NX2: begin
          nxr_q   <= rd_word;
          state_q <= S_V2;
        end
        S_V2: begin
          valr_q  <= rd_word;
          state_q <= S_W2;
        end
        S_W2: begin
          w2_q    <= rd_word;
          state_q <= S_WE;
        end
        S_WE: begin
          wraps_q <= loop_q && (w2_q == rd_word);
          state_q <= S_M1;
        end
        S_M1: state_q <= S_M1W;
        S_M1W: begin
          if (mul_rsp.done) begin
            total_q <= mul_rsp.value;
            state_q <= S_M2W;
          end
        end
        S_M2W: begin
          if (mul_rsp.done) begin
            total_q  <= total_q + $signed(mul_rsp.value);
            weight_q <= dur16;
            state_q  <= S_FWD;
          end
        end
        S_FWD: begin
          if (fwd_near || wraps_q) begin
            near_q  <= fwd_near;
            side_q  <= 1'b0;
            state_q <= S_FD;
          end else begin
            state_q <= S_BWD;
          end
        end
        S_FD: begin
          fd_q    <= rd_word;
          state_q <= S_FF;
        end
        S_FF: state_q <= (fd_q != '0) ? S_C1 : S_ADD;
        S_C1: begin
          if (mul_rsp.done) begin
            state_q <= S_C2;
          end
        end
        S_C2: begin
          if (mul_rsp.done) begin
            state_q <= S_C3;
          end
        end
        S_C3: begin
          if (div_rsp.done) begin
            total_q <= total_q + $signed(div_rsp.value);
            state_q <= S_ADD;
          end
        end
        S_ADD: state_q <= S_ADDW;
        S_ADDW: begin
          if (mul_rsp.done) begin
            total_q  <= total_q + $signed(mul_rsp.value);
            weight_q <= weight_q + (side_q ? dmt : t_q);
            state_q  <= side_q ? S_FIN : S_BWD;
          end
        end
        S_BWD: begin
          if (bwd_near || wraps_q) begin
            near_q  <= bwd_near;
            side_q  <= 1'b1;
            state_q <= S_FD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (weight_q == '0) begin
            fault_q <= 1'b1;
            res_q   <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            res_q   <= div_rsp.value;
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_item_q.curve_value       <= res_q[TIME_W-1:0];
            out_item_q.zero_weight_fault <= fault_q;
            out_valid_q                  <= 1'b1;
            state_q                      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
